### rtl/usrs_pkg.sv
package usrs_pkg;

    // Codepoint and counter widths
    localparam int CP_W     = 21;
    localparam int CNT_W    = 16;
    localparam int CFG_W    = 21;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HAN_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HAN_HIGH = 1'b1;

    // Reset values of the Han range
    localparam logic [CFG_W-1:0] HAN_LOW_RST  = 21'h004E00;
    localparam logic [CFG_W-1:0] HAN_HIGH_RST = 21'h009FA5;

    // Language codes
    localparam logic [1:0] LANG_HAN   = 2'd0;
    localparam logic [1:0] LANG_LATIN = 2'd1;
    localparam logic [1:0] LANG_OTHER = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // One finished character, from the decoder to the run tracker
    typedef struct packed {
        logic            valid;
        logic [1:0]      lang;
        logic [2:0]      nbytes;
    } t_char_evt;

    // One result beat
    typedef struct packed {
        logic [1:0]       run_lang;
        logic [CNT_W-1:0] run_bytes;
        logic [CNT_W-1:0] run_chars;
        logic             text_done;
        logic             last_of_burst;
    } t_result;

    // Results produced by one input beat, in order
    typedef struct packed {
        logic [1:0] n;
        t_result    first;
        t_result    second;
    } t_push;

    // Run tracker status
    typedef struct packed {
        logic       open;
        logic [1:0] lang;
    } t_run_status;

endpackage

### rtl/usrs_byte_if.sv
interface usrs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

### rtl/usrs_run_if.sv
interface usrs_run_if;
    logic        valid;
    logic        ready;
    logic [1:0]  run_lang;
    logic [15:0] run_bytes;
    logic [15:0] run_chars;
    logic        text_done;
    logic        last_of_burst;

    modport source (output valid, output run_lang, output run_bytes, output run_chars,
                    output text_done, output last_of_burst, input ready);
    modport sink   (input valid, input run_lang, input run_bytes, input run_chars,
                    input text_done, input last_of_burst, output ready);
endinterface

### rtl/usrs_decode.sv
module usrs_decode (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [7:0]                      i_byte,
    input  logic                            i_eot,
    input  logic                            i_cfg_we,
    input  logic [usrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [usrs_pkg::CFG_W-1:0]      i_cfg_data,
    output usrs_pkg::t_char_evt             o_char,
    output logic [1:0]                      o_pending
);
    import usrs_pkg::*;

    logic [CP_W-1:0]  r_acc, n_acc;
    logic [1:0]       r_pend, n_pend;
    logic [2:0]       r_cbc, n_cbc;
    logic [CFG_W-1:0] r_han_low, r_han_high;
    logic [CP_W-1:0]  cp;
    logic             done;
    logic             stray;

    // Byte assembly, with zero fill on a truncated character
    always_comb begin
        n_acc  = r_acc;
        n_pend = r_pend;
        n_cbc  = r_cbc;
        done   = 1'b0;
        stray  = 1'b0;
        if (r_pend == 2'd0) begin
            n_cbc = 3'd1;
            if (i_byte >= 8'hF0) begin
                n_acc  = {18'd0, i_byte[2:0]};
                n_pend = 2'd3;
            end else if (i_byte >= 8'hE0) begin
                n_acc  = {17'd0, i_byte[3:0]};
                n_pend = 2'd2;
            end else if (i_byte >= 8'hC0) begin
                n_acc  = {16'd0, i_byte[4:0]};
                n_pend = 2'd1;
            end else begin
                n_acc = {13'd0, i_byte};
                stray = i_byte[7];
                done  = 1'b1;
            end
        end else begin
            n_acc  = {r_acc[CP_W-7:0], i_byte[5:0]};
            n_cbc  = r_cbc + 3'd1;
            n_pend = r_pend - 2'd1;
            done   = (r_pend == 2'd1);
        end
        cp = n_acc;
        if (!done && i_eot) begin
            case (n_pend)
                2'd1:    cp = {n_acc[CP_W-7:0], 6'd0};
                2'd2:    cp = {n_acc[CP_W-13:0], 12'd0};
                2'd3:    cp = {n_acc[CP_W-19:0], 18'd0};
                default: cp = n_acc;
            endcase
        end
    end

    // Classification
    always_comb begin
        o_char.valid  = i_accept && (done || i_eot);
        o_char.nbytes = n_cbc;
        if (stray) begin
            o_char.lang = LANG_OTHER;
        end else if (cp >= r_han_low && cp <= r_han_high) begin
            o_char.lang = LANG_HAN;
        end else if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A)) begin
            o_char.lang = LANG_LATIN;
        end else begin
            o_char.lang = LANG_OTHER;
        end
    end

    assign o_pending = r_pend;

    // Decoder state and Han range registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_pend     <= '0;
            r_cbc      <= '0;
            r_han_low  <= HAN_LOW_RST;
            r_han_high <= HAN_HIGH_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_HAN_LOW:  r_han_low  <= i_cfg_data;
                    REG_HAN_HIGH: r_han_high <= i_cfg_data;
                    default:      r_han_low  <= r_han_low;
                endcase
            end
            if (i_accept) begin
                if (done || i_eot) begin
                    r_acc  <= '0;
                    r_cbc  <= '0;
                    r_pend <= '0;
                end else begin
                    r_acc  <= n_acc;
                    r_cbc  <= n_cbc;
                    r_pend <= n_pend;
                end
            end
        end
    end

endmodule

### rtl/usrs_run.sv
module usrs_run (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_eot,
    input  usrs_pkg::t_char_evt   i_char,
    output usrs_pkg::t_push       o_push,
    output usrs_pkg::t_run_status o_status
);
    import usrs_pkg::*;

    logic             r_open, a_open;
    logic [1:0]       r_lang, a_lang;
    logic [CNT_W-1:0] r_bytes, a_bytes;
    logic [CNT_W-1:0] r_chars, a_chars;
    logic             close;
    logic             eot_emit;
    logic [CNT_W:0]   sum_bytes;
    logic [CNT_W:0]   sum_chars;
    t_result          res_close;
    t_result          res_eot;

    assign sum_bytes = {1'b0, r_bytes} + {{(CNT_W-2){1'b0}}, i_char.nbytes};
    assign sum_chars = {1'b0, r_chars} + {{CNT_W{1'b0}}, 1'b1};

    // Run update for the finished character
    always_comb begin
        a_open  = r_open;
        a_lang  = r_lang;
        a_bytes = r_bytes;
        a_chars = r_chars;
        close   = 1'b0;
        if (i_char.valid) begin
            if (!r_open) begin
                a_open  = 1'b1;
                a_lang  = i_char.lang;
                a_bytes = {{(CNT_W-3){1'b0}}, i_char.nbytes};
                a_chars = {{(CNT_W-1){1'b0}}, 1'b1};
            end else if (r_lang == LANG_OTHER || i_char.lang == r_lang
                         || i_char.lang == LANG_OTHER) begin
                if (r_lang == LANG_OTHER) begin
                    a_lang = i_char.lang;
                end
                a_bytes = sum_bytes[CNT_W] ? CNT_MAX : sum_bytes[CNT_W-1:0];
                a_chars = sum_chars[CNT_W] ? CNT_MAX : sum_chars[CNT_W-1:0];
            end else begin
                close   = 1'b1;
                a_lang  = i_char.lang;
                a_bytes = {{(CNT_W-3){1'b0}}, i_char.nbytes};
                a_chars = {{(CNT_W-1){1'b0}}, 1'b1};
            end
        end
        eot_emit = i_eot && a_open;
    end

    // Result beats for this byte
    always_comb begin
        res_close.run_lang      = r_lang;
        res_close.run_bytes     = r_bytes;
        res_close.run_chars     = r_chars;
        res_close.text_done     = 1'b0;
        res_close.last_of_burst = !eot_emit;
        res_eot.run_lang        = a_lang;
        res_eot.run_bytes       = a_bytes;
        res_eot.run_chars       = a_chars;
        res_eot.text_done       = 1'b1;
        res_eot.last_of_burst   = 1'b1;
        o_push.second           = res_eot;
        if (!i_accept) begin
            o_push.n     = 2'd0;
            o_push.first = res_close;
        end else if (close) begin
            o_push.n     = eot_emit ? 2'd2 : 2'd1;
            o_push.first = res_close;
        end else begin
            o_push.n     = eot_emit ? 2'd1 : 2'd0;
            o_push.first = res_eot;
        end
    end

    assign o_status.open = r_open;
    assign o_status.lang = r_lang;

    // Run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open  <= 1'b0;
            r_lang  <= LANG_OTHER;
            r_bytes <= '0;
            r_chars <= '0;
        end else if (i_accept) begin
            if (i_eot) begin
                r_open  <= 1'b0;
                r_lang  <= LANG_OTHER;
                r_bytes <= '0;
                r_chars <= '0;
            end else begin
                r_open  <= a_open;
                r_lang  <= a_lang;
                r_bytes <= a_bytes;
                r_chars <= a_chars;
            end
        end
    end

endmodule

### rtl/usrs_fifo.sv
module usrs_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  usrs_pkg::t_push                     i_push,
    input  logic                                i_pop,
    output usrs_pkg::t_result                   o_head,
    output logic [usrs_pkg::FIFO_CNT_W-1:0]     o_count
);
    import usrs_pkg::*;

    t_result               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_PTR_W-1:0] wr_next;
    logic                  pop;

    assign wr_next = r_wr_ptr + 1'b1;
    assign pop     = i_pop && (r_count != '0);
    assign o_head  = mem[r_rd_ptr];
    assign o_count = r_count;

    // Storage: up to two writes a cycle at consecutive slots
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.n == 2'd2) begin
            mem[wr_next] <= i_push.second;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(i_push.n);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(i_push.n) - FIFO_CNT_W'(pop);
        end
    end

endmodule

### rtl/utf8_script_run_segmenter_core.sv
// Channel   Dir  Beat contents
// i_text    in   text_byte, end_of_text
// o_run     out  run_lang, run_bytes, run_chars, text_done, last_of_burst
// i_cfg_*   in   write enable, register index, 21-bit data (han_low, han_high)
//
// One input byte per cycle: decode, classify and run update sit between the
// decoder/run registers and a 4-entry result queue, so the byte is done in the
// cycle it is taken and its results are visible the next cycle.
// A byte may produce two result beats; i_text.ready drops while the queue holds
// more than two beats, so a stalled sink backs up into the byte stream.
// Reset is synchronous, active low, and clears all run state and the queue.
module utf8_script_run_segmenter_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    usrs_byte_if.sink                       i_text,
    usrs_run_if.source                      o_run,
    input  logic                            i_cfg_we,
    input  logic [usrs_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [usrs_pkg::CFG_W-1:0]      i_cfg_data
);
    import usrs_pkg::*;

    logic                  accept;
    t_char_evt             char_evt;
    logic [1:0]            pending;
    t_push                 push;
    t_run_status           run_status;
    t_result               head;
    logic [FIFO_CNT_W-1:0] count;

    // Room for two more beats
    assign i_text.ready = (count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign accept       = i_text.valid && i_text.ready;

    usrs_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_byte     (i_text.text_byte),
        .i_eot      (i_text.end_of_text),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_char     (char_evt),
        .o_pending  (pending)
    );

    usrs_run u_run (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_eot    (i_text.end_of_text),
        .i_char   (char_evt),
        .o_push   (push),
        .o_status (run_status)
    );

    usrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_run.ready),
        .o_head  (head),
        .o_count (count)
    );

    // Output beat
    assign o_run.valid         = (count != '0);
    assign o_run.run_lang      = head.run_lang;
    assign o_run.run_bytes     = head.run_bytes;
    assign o_run.run_chars     = head.run_chars;
    assign o_run.text_done     = head.text_done;
    assign o_run.last_of_burst = head.last_of_burst;

    // Queue never overfills
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overfilled");

    // End of text leaves decoder and run tracker in reset state
    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_text.end_of_text |=> !run_status.open && pending == 2'd0
            && run_status.lang == LANG_OTHER)
        else $error("state not cleared after end of text");

    // End of text with an open run always yields a beat
    a_eot_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_text.end_of_text && run_status.open |=> count != '0)
        else $error("open run not emitted at end of text");

    // A byte is never taken without room for its results
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.n != 2'd0 |-> count <= FIFO_CNT_W'(FIFO_DEPTH - 2))
        else $error("push without room");

endmodule
